### hdl/adcma_pkg.sv
// Shared widths and constants for the ADC moving-average monitor.
package adcma_pkg;

   localparam int SAMPLE_W = 12;
   localparam int AVG_W    = 14;
   localparam int MV_W     = 17;
   localparam int WIN_W    = 7;
   localparam int PTR_W    = 6;
   localparam int DIFF_W   = SAMPLE_W + 1;
   localparam int SUM_W    = AVG_W + 1;
   localparam int SCALE_W  = 13;
   localparam int MV_SHIFT = 10;
   localparam int CNT_W    = 4;

   localparam int MAX_WINDOW = 64;

   localparam logic [WIN_W-1:0]   WIN_RESET = 7'd4;
   localparam logic [WIN_W-1:0]   WIN_MIN   = 7'd1;
   localparam logic [WIN_W-1:0]   WIN_MAX   = 7'(MAX_WINDOW);
   localparam logic [SCALE_W-1:0] MV_SCALE  = 13'd4705;

   localparam logic signed [SUM_W-1:0] AVG_MIN = -15'sd4096;
   localparam logic signed [SUM_W-1:0] AVG_MAX = 15'sd8191;

   localparam logic [CNT_W-1:0] DIV_LAST = 4'(SAMPLE_W - 1);
   localparam logic [CNT_W-1:0] MUL_LAST = 4'(SCALE_W - 1);

endpackage

### hdl/adc_moving_average_monitor_top.sv
// ADC moving-average monitor: ring of samples, serial divide, serial scale to millivolts.
// Sequence: a priming request goes from acceptance straight to the bit-serial multiply by
// the millivolt scale; a later request passes an operand state, a bit-serial divide by the
// window, an accumulate state and then the bit-serial multiply by the millivolt scale.
// A new request is taken only in idle, once the last result has been passed to the output.
// Synchronous active-high reset clears control state and loads a window of 4.
module adc_moving_average_monitor_top
   import adcma_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [SAMPLE_W-1:0]        req_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [AVG_W-1:0]    rsp_average,
   output logic signed [MV_W-1:0]     rsp_voltage_mv,
   input  logic                       csr_we,
   input  logic [WIN_W-1:0]           csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_SUM,
      ST_MUL,
      ST_FIN
   } state_type;

   state_type                 state_ff, state_in;
   logic [WIN_W-1:0]          win_ff, win_in;
   logic                      primed_ff, primed_in;
   logic                      wrapped_ff, wrapped_in;
   logic [PTR_W-1:0]          ptr_ff, ptr_in;
   logic [SAMPLE_W-1:0]       prime_ff, prime_in;
   logic [SAMPLE_W-1:0]       samp_ff, samp_in;
   logic                      sel_ff, sel_in;
   logic signed [AVG_W-1:0]   avg_ff, avg_in;
   logic                      neg_ff, neg_in;
   logic [SAMPLE_W-1:0]       quo_ff, quo_in;
   logic [PTR_W-1:0]          rem_ff, rem_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic signed [SUM_W-1:0]   hi_ff, hi_in;
   logic [SCALE_W-1:0]        lo_ff, lo_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [AVG_W-1:0]   rsp_avg_ff, rsp_avg_in;
   logic signed [MV_W-1:0]    rsp_mv_ff, rsp_mv_in;

   logic [SAMPLE_W-1:0]       mem [MAX_WINDOW];
   logic [SAMPLE_W-1:0]       rd_ff;

   logic [WIN_W-1:0]          weff;
   logic [SAMPLE_W-1:0]       oldest;
   logic signed [DIFF_W-1:0]  diff;
   logic [WIN_W-1:0]          shifted;
   logic [WIN_W:0]            trial;
   logic signed [DIFF_W-1:0]  quo_s;
   logic signed [SUM_W-1:0]   sum;
   logic signed [SUM_W-1:0]   hi_sum;
   logic [WIN_W-1:0]          ptr_inc;
   logic                      accept;

   assign req_ready      = (state_ff == ST_IDLE);
   assign accept         = req_valid && req_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_average    = rsp_avg_ff;
   assign rsp_voltage_mv = rsp_mv_ff;

   always_comb begin
      state_in     = state_ff;
      win_in       = win_ff;
      primed_in    = primed_ff;
      wrapped_in   = wrapped_ff;
      ptr_in       = ptr_ff;
      prime_in     = prime_ff;
      samp_in      = samp_ff;
      sel_in       = sel_ff;
      avg_in       = avg_ff;
      neg_in       = neg_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_avg_in   = rsp_avg_ff;
      rsp_mv_in    = rsp_mv_ff;

      if (win_ff == '0) begin
         weff = WIN_MIN;
      end else if (win_ff > WIN_MAX) begin
         weff = WIN_MAX;
      end else begin
         weff = win_ff;
      end

      ptr_inc = {1'b0, ptr_ff} + 7'd1;
      oldest  = sel_ff ? rd_ff : prime_ff;
      diff    = $signed({1'b0, samp_ff}) - $signed({1'b0, oldest});
      shifted = {rem_ff, quo_ff[SAMPLE_W-1]};
      trial   = {1'b0, shifted} - {1'b0, weff};
      quo_s   = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
      sum     = SUM_W'(avg_ff) + SUM_W'(quo_s);
      hi_sum  = hi_ff + (MV_SCALE[cnt_ff] ? SUM_W'(avg_ff) : '0);

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               samp_in = req_sample;
               cnt_in  = '0;
               if (!primed_ff) begin
                  avg_in     = $signed({2'b00, req_sample});
                  prime_in   = req_sample;
                  primed_in  = 1'b1;
                  ptr_in     = '0;
                  wrapped_in = 1'b0;
                  hi_in      = '0;
                  state_in   = ST_MUL;
               end else begin
                  sel_in = wrapped_ff;
                  if (ptr_inc >= weff) begin
                     ptr_in     = '0;
                     wrapped_in = 1'b1;
                  end else begin
                     ptr_in = ptr_inc[PTR_W-1:0];
                  end
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            neg_in   = diff[DIFF_W-1];
            quo_in   = diff[DIFF_W-1] ? SAMPLE_W'(-diff) : SAMPLE_W'(diff);
            rem_in   = '0;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = trial[WIN_W] ? shifted[PTR_W-1:0] : trial[PTR_W-1:0];
            quo_in = {quo_ff[SAMPLE_W-2:0], ~trial[WIN_W]};
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            if (sum < AVG_MIN) begin
               avg_in = AVG_MIN[AVG_W-1:0];
            end else if (sum > AVG_MAX) begin
               avg_in = AVG_MAX[AVG_W-1:0];
            end else begin
               avg_in = sum[AVG_W-1:0];
            end
            hi_in    = '0;
            cnt_in   = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            hi_in  = hi_sum >>> 1;
            lo_in  = {hi_sum[0], lo_ff[SCALE_W-1:1]};
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == MUL_LAST) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_avg_in   = avg_ff;
               rsp_mv_in    = {hi_ff[AVG_W-1:0], lo_ff[SCALE_W-1:MV_SHIFT]};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_we) begin
         win_in     = csr_wdata;
         primed_in  = 1'b0;
         ptr_in     = '0;
         wrapped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         win_ff       <= WIN_RESET;
         primed_ff    <= 1'b0;
         wrapped_ff   <= 1'b0;
         ptr_ff       <= '0;
         avg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         win_ff       <= win_in;
         primed_ff    <= primed_in;
         wrapped_ff   <= wrapped_in;
         ptr_ff       <= ptr_in;
         avg_ff       <= avg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      prime_ff   <= prime_in;
      samp_ff    <= samp_in;
      sel_ff     <= sel_in;
      neg_ff     <= neg_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      cnt_ff     <= cnt_in;
      hi_ff      <= hi_in;
      lo_ff      <= lo_in;
      rsp_avg_ff <= rsp_avg_in;
      rsp_mv_ff  <= rsp_mv_in;
   end

   // read-before-write: rd_ff holds the sample being displaced
   always_ff @(posedge clock) begin
      if (accept && primed_ff) begin
         mem[ptr_ff] <= req_sample;
      end
      rd_ff <= mem[ptr_ff];
   end

`ifndef SYNTHESIS
   a_ptr_in_window: assert property (@(posedge clock) disable iff (reset)
      primed_ff |-> ({1'b0, ptr_ff} < weff))
      else $error("slot pointer outside window");

   a_avg_range: assert property (@(posedge clock) disable iff (reset)
      $signed(SUM_W'(avg_ff)) >= AVG_MIN)
      else $error("average below saturation floor");

   a_rem_below_win: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM) |-> ({1'b0, rem_ff} < weff))
      else $error("divider remainder not below window");

   a_cfg_unprimes: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> (!primed_ff && ptr_ff == '0))
      else $error("configuration write did not restart priming");
`endif

endmodule
